FILE: hw/rtl/bqp_pkg.sv
// shared types, constants and helpers for the bounded queue with promote
package bqp_pkg;

   // queue depth and derived widths
   localparam int CAPACITY = 8;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int TOTAL_W  = $clog2(CAPACITY * 15 + 1);
   localparam int WAIT_W   = 7;
   localparam int SUM_W    = (TOTAL_W > WAIT_W) ? TOTAL_W : WAIT_W;
   localparam int WAIT_MAX = 127;

   // command codes
   localparam logic [1:0] CMD_ENQ   = 2'd0;
   localparam logic [1:0] CMD_DEQ   = 2'd1;
   localparam logic [1:0] CMD_PROMO = 2'd2;

   // result status codes
   localparam logic [2:0] ST_ENQUEUED     = 3'd0;
   localparam logic [2:0] ST_FULL         = 3'd1;
   localparam logic [2:0] ST_SERVED       = 3'd2;
   localparam logic [2:0] ST_EMPTY        = 3'd3;
   localparam logic [2:0] ST_PROMO_SERVED = 3'd4;
   localparam logic [2:0] ST_MOVED        = 3'd5;
   localparam logic [2:0] ST_NOT_FOUND    = 3'd6;

   // one stored queue entry
   typedef struct packed {
      logic [7:0] id;
      logic [3:0] tm;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // sequencer states
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_HEAD_RD,
      SEQ_SCAN,
      SEQ_SHIFT_RD,
      SEQ_SHIFT_WR,
      SEQ_FRONT,
      SEQ_RESP
   } state_type;

   // physical slot of a logical position in the circular store
   function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W:0]   off);
      logic [ADDR_W+1:0] sum;
      sum = {2'b00, base} + {1'b0, off};
      if (sum >= (ADDR_W + 2)'(CAPACITY)) begin
         sum = sum - (ADDR_W + 2)'(CAPACITY);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/bounded_queue_with_promote.sv
// bounded fifo with dequeue and promote-to-front, one ram scanned by a sequencer
//
//  channel   | payload ports                                          | handshake
//  req (in)  | req_cmd, req_item_id, req_service_time                 | req_valid / req_stall
//  rsp (out) | rsp_status, rsp_out_id, rsp_wait_total, rsp_wait_valid | rsp_valid / rsp_stall
//
// enqueue and rejected commands go from idle straight to the response state, dequeue passes through the head read
// promote scans one ram entry per cycle through the single read port, then moves
// the entries ahead of the match back one at a time, each with a read and a write state
// a new command is taken only while the sequencer is idle; one result may wait in the
// output register while the next command runs
// reset is synchronous and empties the queue at once; the ram needs no clearing
module bounded_queue_with_promote (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_item_id,
   input  logic [3:0] req_service_time,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_out_id,
   output logic [6:0] rsp_wait_total,
   output logic       rsp_wait_valid
);

   bqp_pkg::state_type              state_ff, state_in;
   logic [bqp_pkg::ADDR_W-1:0]      head_ff, head_in;
   logic [bqp_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [bqp_pkg::SUM_W-1:0]       total_ff, total_in;
   logic [bqp_pkg::ADDR_W-1:0]      idx_ff, idx_in;
   logic [7:0]                      key_ff, key_in;
   logic [2:0]                      res_status_ff, res_status_in;
   logic [7:0]                      res_id_ff, res_id_in;
   logic [bqp_pkg::WAIT_W-1:0]      res_wait_ff, res_wait_in;
   logic                            res_wval_ff, res_wval_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [2:0]                      rsp_status_ff;
   logic [7:0]                      rsp_out_id_ff;
   logic [bqp_pkg::WAIT_W-1:0]      rsp_wait_total_ff;
   logic                            rsp_wait_valid_ff;
   logic                            rsp_load;

   logic                            ram_we;
   logic [bqp_pkg::ADDR_W-1:0]      ram_waddr;
   logic [bqp_pkg::ADDR_W-1:0]      ram_raddr;
   bqp_pkg::entry_type              ram_wdata;
   bqp_pkg::entry_type              ram_rdata;
   logic [bqp_pkg::SUM_W-1:0]       enq_sum;

   // entry store
   bqp_ram #(
      .WIDTH (bqp_pkg::ENTRY_W),
      .DEPTH (bqp_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign enq_sum = total_ff + bqp_pkg::SUM_W'(req_service_time);

   // sequencer next state, ram control and queue bookkeeping
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_wait_in   = res_wait_ff;
      res_wval_in   = res_wval_ff;
      ram_we        = 1'b0;
      ram_waddr     = head_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = head_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         bqp_pkg::SEQ_IDLE: begin
            res_id_in   = 8'd0;
            res_wait_in = '0;
            res_wval_in = 1'b0;
            key_in      = req_item_id;
            idx_in      = '0;
            if (req_valid) begin
               case (req_cmd)
                  bqp_pkg::CMD_ENQ: begin
                     state_in = bqp_pkg::SEQ_RESP;
                     if (count_ff == bqp_pkg::COUNT_W'(bqp_pkg::CAPACITY)) begin
                        res_status_in = bqp_pkg::ST_FULL;
                     end else begin
                        ram_we        = 1'b1;
                        ram_waddr     = bqp_pkg::slot_of(head_ff,
                                           (bqp_pkg::ADDR_W + 1)'(count_ff));
                        ram_wdata.id  = req_item_id;
                        ram_wdata.tm  = req_service_time;
                        count_in      = count_ff + 1'b1;
                        total_in      = enq_sum;
                        res_status_in = bqp_pkg::ST_ENQUEUED;
                        res_wait_in   = (enq_sum > bqp_pkg::SUM_W'(bqp_pkg::WAIT_MAX)) ?
                                        bqp_pkg::WAIT_W'(bqp_pkg::WAIT_MAX) :
                                        enq_sum[bqp_pkg::WAIT_W-1:0];
                        res_wval_in   = (count_ff != '0);
                     end
                  end
                  bqp_pkg::CMD_DEQ: begin
                     if (count_ff == '0) begin
                        res_status_in = bqp_pkg::ST_EMPTY;
                        state_in      = bqp_pkg::SEQ_RESP;
                     end else begin
                        state_in = bqp_pkg::SEQ_HEAD_RD;
                     end
                  end
                  bqp_pkg::CMD_PROMO: begin
                     if (count_ff == '0) begin
                        res_status_in = bqp_pkg::ST_NOT_FOUND;
                        state_in      = bqp_pkg::SEQ_RESP;
                     end else begin
                        state_in = bqp_pkg::SEQ_SCAN;
                     end
                  end
                  default: begin
                     state_in = bqp_pkg::SEQ_IDLE;
                  end
               endcase
            end
         end

         // head entry is on the read port: pop it
         bqp_pkg::SEQ_HEAD_RD: begin
            res_status_in = bqp_pkg::ST_SERVED;
            res_id_in     = ram_rdata.id;
            total_in      = total_ff - bqp_pkg::SUM_W'(ram_rdata.tm);
            head_in       = bqp_pkg::slot_of(head_ff, (bqp_pkg::ADDR_W + 1)'(1));
            count_in      = count_ff - 1'b1;
            state_in      = bqp_pkg::SEQ_RESP;
         end

         // compare one entry per cycle, read the next one ahead
         bqp_pkg::SEQ_SCAN: begin
            ram_raddr = bqp_pkg::slot_of(head_ff, {1'b0, idx_ff} + 1'b1);
            if (ram_rdata.id == key_ff) begin
               res_id_in = key_ff;
               total_in  = total_ff - bqp_pkg::SUM_W'(ram_rdata.tm);
               if (idx_ff == '0) begin
                  res_status_in = bqp_pkg::ST_PROMO_SERVED;
                  head_in       = bqp_pkg::slot_of(head_ff, (bqp_pkg::ADDR_W + 1)'(1));
                  count_in      = count_ff - 1'b1;
                  state_in      = bqp_pkg::SEQ_RESP;
               end else begin
                  res_status_in = bqp_pkg::ST_MOVED;
                  state_in      = bqp_pkg::SEQ_SHIFT_RD;
               end
            end else if (bqp_pkg::COUNT_W'(idx_ff) + 1'b1 == count_ff) begin
               res_status_in = bqp_pkg::ST_NOT_FOUND;
               state_in      = bqp_pkg::SEQ_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // fetch the entry just ahead of the hole
         bqp_pkg::SEQ_SHIFT_RD: begin
            ram_raddr = bqp_pkg::slot_of(head_ff, {1'b0, idx_ff} - 1'b1);
            state_in  = bqp_pkg::SEQ_SHIFT_WR;
         end

         // move it back one place
         bqp_pkg::SEQ_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = bqp_pkg::slot_of(head_ff, {1'b0, idx_ff});
            ram_wdata = ram_rdata;
            idx_in    = idx_ff - 1'b1;
            if (idx_ff == bqp_pkg::ADDR_W'(1)) begin
               state_in = bqp_pkg::SEQ_FRONT;
            end else begin
               state_in = bqp_pkg::SEQ_SHIFT_RD;
            end
         end

         // promoted entry goes to the head with zero time
         bqp_pkg::SEQ_FRONT: begin
            ram_we       = 1'b1;
            ram_waddr    = head_ff;
            ram_wdata.id = key_ff;
            ram_wdata.tm = 4'd0;
            state_in     = bqp_pkg::SEQ_RESP;
         end

         // hand the result to the output register once it is free
         bqp_pkg::SEQ_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = bqp_pkg::SEQ_IDLE;
            end
         end

         default: begin
            state_in = bqp_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bqp_pkg::SEQ_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_wait_ff   <= res_wait_in;
      res_wval_ff   <= res_wval_in;
      if (rsp_load) begin
         rsp_status_ff     <= res_status_ff;
         rsp_out_id_ff     <= res_id_ff;
         rsp_wait_total_ff <= res_wait_ff;
         rsp_wait_valid_ff <= res_wval_ff;
      end
   end

   assign req_stall      = (state_ff != bqp_pkg::SEQ_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_id     = rsp_out_id_ff;
   assign rsp_wait_total = rsp_wait_total_ff;
   assign rsp_wait_valid = rsp_wait_valid_ff;

   // occupancy never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bqp_pkg::COUNT_W'(bqp_pkg::CAPACITY))
      else $error("queue count above capacity");

   // the scan never runs past the last queued entry
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bqp_pkg::SEQ_SCAN) |-> (bqp_pkg::COUNT_W'(idx_ff) < count_ff))
      else $error("scan index beyond queue end");

   // a dequeue on a non-empty queue removes exactly one entry
   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bqp_pkg::SEQ_HEAD_RD) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("dequeue did not remove one entry");

   // moving an entry to the front keeps the count
   a_move_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bqp_pkg::SEQ_SHIFT_WR) |=> $stable(count_ff))
      else $error("count changed while moving an entry");

endmodule

FILE: hw/rtl/bqp_ram.sv
// generic single write port ram with registered read
module bqp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: dv/tb_bounded_queue_with_promote.sv
// self-checking testbench for the bounded queue with promote
`timescale 1ns / 1ps

module tb_bounded_queue_with_promote;

   // unused command code, ignored by the block
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 12;
   localparam int RANDOM_ITEMS   = 500;
   localparam int CALM_TAIL      = 60;
   localparam int TAIL_CYCLES    = 3 * bqp_pkg::CAPACITY + 20;
   localparam int WATCHDOG_LIMIT = 2000;

   // one command as driven on the request channel
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] item_id;
      logic [3:0] service_time;
      logic       drain_first;
   } cmd_item_type;

   // one reply as seen on the response channel
   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_id;
      logic [6:0] wait_total;
      logic       wait_valid;
   } reply_type;

   // queue contents, oldest entry at position 0
   typedef struct packed {
      logic [bqp_pkg::CAPACITY-1:0][7:0] ids;
      logic [bqp_pkg::CAPACITY-1:0][3:0] times;
      logic [bqp_pkg::COUNT_W-1:0]       count;
   } queue_image_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_cmd = bqp_pkg::CMD_ENQ;
   logic [7:0] req_item_id = 8'd0;
   logic [3:0] req_service_time = 4'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [7:0] rsp_out_id;
   logic [6:0] rsp_wait_total;
   logic       rsp_wait_valid;

   cmd_item_type    pending_cmds[$];
   reply_type       expected_replies[$];
   queue_image_type live_queue;
   queue_image_type plan_queue;
   cmd_item_type    cur_item;
   int              total_cmds = 0;
   int              accepted_cmds = 0;
   int              error_count = 0;
   int              quiet_cycles = 0;
   int              idle_left = 0;
   int              stall_left = 0;
   logic            calm = 1'b0;

   bounded_queue_with_promote u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_item_id      (req_item_id),
      .req_service_time (req_service_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_wait_total   (rsp_wait_total),
      .rsp_wait_valid   (rsp_wait_valid)
   );

   // clock
   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // applies one command to a queue image, returns 1 when a reply is due
   function automatic bit queue_step(inout queue_image_type q, input cmd_item_type c,
                                     output reply_type r);
      int         pos;
      int         sum;
      bit         found;
      logic [7:0] oid;
      r = '0;
      pos = 0;
      sum = 0;
      found = 1'b0;
      oid = 8'd0;
      if (c.cmd == bqp_pkg::CMD_ENQ) begin
         if (q.count >= bqp_pkg::COUNT_W'(bqp_pkg::CAPACITY)) begin
            r.status = bqp_pkg::ST_FULL;
         end else begin
            q.ids[q.count] = c.item_id;
            q.times[q.count] = c.service_time;
            q.count = q.count + 1'b1;
            for (int i = 0; i < q.count; i++) sum += q.times[i];
            r.status = bqp_pkg::ST_ENQUEUED;
            r.wait_total = (sum > bqp_pkg::WAIT_MAX) ? 7'(bqp_pkg::WAIT_MAX) : 7'(sum);
            r.wait_valid = (q.count > 1);
         end
         return 1'b1;
      end
      if (c.cmd == bqp_pkg::CMD_DEQ || c.cmd == bqp_pkg::CMD_PROMO) begin
         // first matching entry, only for promote
         if (c.cmd == bqp_pkg::CMD_PROMO) begin
            for (int i = 0; i < q.count; i++) begin
               if (!found && q.ids[i] == c.item_id) begin
                  found = 1'b1;
                  pos = i;
               end
            end
         end else begin
            found = (q.count != 0);
         end
         if (!found) begin
            r.status = (c.cmd == bqp_pkg::CMD_DEQ) ? bqp_pkg::ST_EMPTY :
                                                     bqp_pkg::ST_NOT_FOUND;
         end else if (pos == 0) begin
            // serve the head and close the gap
            r.out_id = q.ids[0];
            for (int i = 0; i + 1 < q.count; i++) begin
               q.ids[i] = q.ids[i+1];
               q.times[i] = q.times[i+1];
            end
            q.count = q.count - 1'b1;
            r.status = (c.cmd == bqp_pkg::CMD_DEQ) ? bqp_pkg::ST_SERVED :
                                                     bqp_pkg::ST_PROMO_SERVED;
         end else begin
            // move to front with zero time, earlier entries slide back
            oid = q.ids[pos];
            for (int i = pos; i > 0; i--) begin
               q.ids[i] = q.ids[i-1];
               q.times[i] = q.times[i-1];
            end
            q.ids[0] = oid;
            q.times[0] = 4'd0;
            r.out_id = oid;
            r.status = bqp_pkg::ST_MOVED;
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // queues one command and tracks the planned queue for promote targets
   task automatic add_cmd(input logic [1:0] cmd, input logic [7:0] id,
                          input logic [3:0] tm, input logic drain);
      cmd_item_type c;
      reply_type    unused;
      c.cmd = cmd;
      c.item_id = id;
      c.service_time = tm;
      c.drain_first = drain;
      void'(queue_step(plan_queue, c, unused));
      pending_cmds.push_back(c);
      total_cmds++;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      reply_type rep;
      bit        free;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         free = !req_valid || !req_stall;
         if (req_valid && !req_stall) begin
            if (queue_step(live_queue, cur_item, rep)) expected_replies.push_back(rep);
            accepted_cmds++;
         end
         calm <= (pending_cmds.size() < CALM_TAIL);
         if (free) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0 &&
                         (!pending_cmds[0].drain_first || expected_replies.size() == 0)) begin
               if (!calm && $urandom_range(0, 99) < 15) begin
                  idle_left = $urandom_range(1, 6) - 1;
                  req_valid <= 1'b0;
               end else begin
                  cur_item = pending_cmds.pop_front();
                  req_valid <= 1'b1;
                  req_cmd <= cur_item.cmd;
                  req_item_id <= cur_item.item_id;
                  req_service_time <= cur_item.service_time;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin : rsp_monitor
      reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual status %0d id %0d",
                        $time, rsp_status, rsp_out_id);
               error_count++;
            end else begin
               want = expected_replies.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("out_id", want.out_id, rsp_out_id);
               check_field("wait_total", want.wait_total, rsp_wait_total);
               check_field("wait_valid", want.wait_valid, rsp_wait_valid);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 99) < 12) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
   end

   // stimulus, end of run
   initial begin : main_seq
      int         counted;
      int         enq_pct;
      int         pick;
      logic [1:0] cmd;
      logic [7:0] id;
      live_queue = '0;
      plan_queue = '0;

      // directed: empty cases, first entry, fill to full, promote variants
      add_cmd(bqp_pkg::CMD_DEQ, 8'h00, 4'd0, 1'b0);
      add_cmd(bqp_pkg::CMD_PROMO, 8'h5A, 4'd7, 1'b0);
      add_cmd(CMD_NONE, 8'hFF, 4'd15, 1'b0);
      add_cmd(bqp_pkg::CMD_ENQ, 8'h00, 4'd0, 1'b0);
      add_cmd(bqp_pkg::CMD_DEQ, 8'hFF, 4'd15, 1'b0);
      add_cmd(bqp_pkg::CMD_ENQ, 8'hFF, 4'd15, 1'b0);
      for (int i = 1; i < bqp_pkg::CAPACITY; i++)
         add_cmd(bqp_pkg::CMD_ENQ, 8'(8'h10 + i), 4'd15, 1'b0);
      add_cmd(bqp_pkg::CMD_ENQ, 8'hAA, 4'd5, 1'b0);
      add_cmd(bqp_pkg::CMD_PROMO, 8'hFF, 4'd0, 1'b0);
      add_cmd(bqp_pkg::CMD_PROMO, 8'(8'h10 + bqp_pkg::CAPACITY - 1), 4'd0, 1'b0);
      add_cmd(bqp_pkg::CMD_PROMO, 8'h33, 4'd0, 1'b0);
      add_cmd(bqp_pkg::CMD_ENQ, 8'h13, 4'd9, 1'b0);
      add_cmd(bqp_pkg::CMD_PROMO, 8'h13, 4'd0, 1'b0);
      add_cmd(CMD_NONE, 8'h00, 4'd0, 1'b0);
      add_cmd(bqp_pkg::CMD_DEQ, 8'h00, 4'd0, 1'b0);
      add_cmd(bqp_pkg::CMD_DEQ, 8'h00, 4'd0, 1'b0);
      add_cmd(bqp_pkg::CMD_ENQ, 8'h80, 4'd8, 1'b0);

      // random: enqueue bias drifts so the queue swings between empty and full
      counted = 0;
      enq_pct = 50;
      while (counted < RANDOM_ITEMS) begin
         if (counted % 50 == 0) enq_pct = $urandom_range(20, 70);
         pick = $urandom_range(0, 99);
         id = 8'($urandom_range(0, 255));
         if (pick < 4) begin
            cmd = CMD_NONE;
         end else if ($urandom_range(0, 99) < enq_pct) begin
            cmd = bqp_pkg::CMD_ENQ;
            if ($urandom_range(0, 99) < 40) id = 8'($urandom_range(0, 7));
         end else if ($urandom_range(0, 99) < 40) begin
            cmd = bqp_pkg::CMD_DEQ;
         end else begin
            cmd = bqp_pkg::CMD_PROMO;
            if (plan_queue.count != 0 && $urandom_range(0, 99) < 80)
               id = plan_queue.ids[$urandom_range(0, plan_queue.count - 1)];
         end
         add_cmd(cmd, id, 4'($urandom_range(0, 15)), (counted % 120 == 0));
         if (cmd != CMD_NONE) counted++;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // wait for every command to be taken and every reply to arrive
      while ((accepted_cmds != total_cmds || expected_replies.size() != 0) &&
             quiet_cycles < WATCHDOG_LIMIT)
         @(negedge clock);
      while (quiet_cycles < TAIL_CYCLES && quiet_cycles < WATCHDOG_LIMIT)
         @(negedge clock);

      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, expected %0d replies pending, actual none seen",
                  $time, expected_replies.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
